/* design/mpbm_pkg.sv */
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared sizes, codes, payload types and address helpers of the
// multi-pattern byte matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbm_pkg;

  // Table sizes
  localparam int NODE_COUNT      = 4096;
  localparam int ALPHABET_SIZE   = 256;
  localparam int MAX_PATTERN_LEN = 16;
  localparam int PATTERN_SLOTS   = 256;
  localparam int RESULT_CAP      = 16;

  // Derived widths
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int CNT_W       = NODE_W + 1;
  localparam int PAT_W       = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int PCNT_W      = $clog2(PATTERN_SLOTS + 1);
  localparam int LEN_W       = $clog2(MAX_PATTERN_LEN + 1);
  localparam int SYM_CNT_W   = $clog2(ALPHABET_SIZE + 1);
  localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int K_W         = $clog2(RESULT_CAP);

  // Field widths
  localparam int SYM_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int PNUM_W      = 8;
  localparam int POS_W       = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + PNUM_W + POS_W);

  typedef enum logic [1:0] {
    KIND_PATTERN  = 2'd0,
    KIND_FINALIZE = 2'd1,
    KIND_TEXT     = 2'd2
  } in_kind_t;

  typedef enum logic [1:0] {
    REPLY_ADD      = 2'd0,
    REPLY_FINALIZE = 2'd1,
    REPLY_MATCH    = 2'd2
  } reply_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_DUPLICATE     = 3'd1,
    ST_TOO_LONG      = 3'd2,
    ST_SYMBOL_RANGE  = 3'd3,
    ST_CLOSED        = 3'd4,
    ST_STILL_OPEN    = 3'd5,
    ST_NODES_FULL    = 3'd6,
    ST_PATTERNS_FULL = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_PAT_CHK,
    S_PAT_ALLOC,
    S_PAT_END,
    S_PAT_FINAL,
    S_FIN_START,
    S_BFS_DEQ,
    S_BFS_U,
    S_BFS_FU,
    S_BFS_CH,
    S_BFS_V,
    S_BFS_WALK,
    S_BFS_WCHK,
    S_BFS_WLNK,
    S_BFS_FL,
    S_BFS_FW,
    S_TX_STEP,
    S_TX_CHK,
    S_TX_LNK,
    S_TX_ADV,
    S_TX_N,
    S_TX_ID,
    S_TX_REP,
    S_REPLY
  } engine_state_t;

  // One classified command from the front end
  typedef struct packed {
    in_kind_t         kind;
    logic [SYM_W-1:0] symbol;
    logic             pattern_end;
    logic             text_start;
  } cmd_t;

  // One result item
  typedef struct packed {
    reply_kind_t       kind;
    status_t           status;
    logic [PNUM_W-1:0] pnum;
    logic [POS_W-1:0]  pos;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [NODE_W-1:0] dict;
    logic [NODE_W-1:0] fail;
  } link_t;

  typedef struct packed {
    logic             is_final;
    logic [PAT_W-1:0] id;
  } info_t;

  // Flat address of one child slot
  function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
                                                     input logic [SYM_W-1:0] sym);
    child_addr = CHILD_AW'(node) * CHILD_AW'(ALPHABET_SIZE) + CHILD_AW'(sym);
  endfunction

  function automatic logic sym_in_range(input logic [SYM_W-1:0] sym);
    sym_in_range = (9'(sym) < 9'(ALPHABET_SIZE));
  endfunction

endpackage

`default_nettype wire

/* design/mpbm_ram.sv */
// ----------------------------------------------------------------------------
// mpbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/mpbm_front.sv */
// ----------------------------------------------------------------------------
// mpbm_front
// Input side: accepts items, drops unused kinds and queues commands for the
// engine in a two-entry buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [mpbm_pkg::SYM_W-1:0]   in_symbol,
  input  logic                         in_end,
  input  logic                         in_start,
  input  logic                         clearing,
  output logic                         cmd_valid,
  output mpbm_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);
  import mpbm_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       known;
  logic       push;

  // Classify the kind code
  always_comb begin
    unique case (in_kind_t'(in_kind))
      KIND_PATTERN, KIND_FINALIZE, KIND_TEXT: known = 1'b1;
      default:                               known = 1'b0;
    endcase
  end

  assign in_ready  = (fill != 2'd2) && !clearing;
  assign push      = in_valid && in_ready && known;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind: in_kind_t'(in_kind), symbol: in_symbol,
                        pattern_end: in_end, text_start: in_start};
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

/* design/mpbm_engine.sv */
// ----------------------------------------------------------------------------
// mpbm_engine
// Back end: trie insertion, breadth-first link build and text scanning over
// the table memories, with a one-entry result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  mpbm_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              clearing,
  input  logic              out_ready,
  output logic              out_valid,
  output mpbm_pkg::result_t out_res
);
  import mpbm_pkg::*;

  engine_state_t state, state_next;

  cmd_t               cmd_q, cmd_q_next;
  logic [CHILD_AW-1:0] clr_addr, clr_addr_next;
  logic [NODE_W-1:0]  cursor, cursor_next;
  logic [LEN_W-1:0]   count, count_next;
  status_t            err, err_next;
  logic [CNT_W-1:0]   nodes_used, nodes_used_next;
  logic [PCNT_W-1:0]  pats_used, pats_used_next;
  logic               open, open_next;
  logic [NODE_W-1:0]  scan_node, scan_node_next;
  logic [POS_W-1:0]   scan_pos, scan_pos_next;
  logic [NODE_W-1:0]  node, node_next;
  logic [NODE_W-1:0]  u, u_next;
  logic [NODE_W-1:0]  fu, fu_next;
  logic [NODE_W-1:0]  v, v_next;
  logic [NODE_W-1:0]  f, f_next;
  logic [NODE_W-1:0]  nn, nn_next;
  logic [CNT_W-1:0]   head, head_next;
  logic [CNT_W-1:0]   tail, tail_next;
  logic [SYM_CNT_W-1:0] c, c_next;
  logic [PAT_W-1:0]   mid, mid_next;
  logic [K_W-1:0]     k, k_next;
  reply_kind_t        rsp_kind, rsp_kind_next;
  status_t            rsp_status, rsp_status_next;
  logic [PNUM_W-1:0]  rsp_pnum, rsp_pnum_next;
  result_t            res_next;
  logic               res_load;

  // Memory ports
  logic                child_we, child_re;
  logic [CHILD_AW-1:0] child_waddr, child_raddr;
  logic [NODE_W-1:0]   child_wdata, child_rdata;
  logic                link_we, link_re;
  logic [NODE_W-1:0]   link_waddr, link_raddr;
  link_t               link_wdata, link_rdata;
  logic                info_we, info_re;
  logic [NODE_W-1:0]   info_waddr, info_raddr;
  info_t               info_wdata, info_rdata;
  logic                plen_we, plen_re;
  logic [PAT_W-1:0]    plen_waddr, plen_raddr;
  logic [LEN_W-1:0]    plen_wdata, plen_rdata;
  logic                q_we, q_re;
  logic [NODE_W-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;

  // Shared conditions
  logic              out_free;
  logic              sym_ok;
  logic              clr_done;
  logic              bfs_more;
  logic              rep_last;
  logic [NODE_W-1:0] tx_first;
  logic [NODE_W-1:0] tx_child;

  assign out_free = !out_valid || out_ready;
  assign sym_ok   = sym_in_range(cmd_q.symbol);
  assign clr_done = (clr_addr == CHILD_AW'(CHILD_DEPTH - 1));
  assign bfs_more = (head < tail);
  assign rep_last = (nn == '0) || (k == K_W'(RESULT_CAP - 1));
  assign tx_first = info_rdata.is_final ? node : link_rdata.dict;
  assign tx_child = sym_ok ? child_rdata : '0;

  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .re(child_re), .raddr(child_raddr), .rdata(child_rdata));

  mpbm_ram #(.WIDTH($bits(link_t)), .DEPTH(NODE_COUNT)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata));

  mpbm_ram #(.WIDTH($bits(info_t)), .DEPTH(NODE_COUNT)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .re(info_re), .raddr(info_raddr), .rdata(info_rdata));

  mpbm_ram #(.WIDTH(LEN_W), .DEPTH(1 << PAT_W)) u_plen (
    .clk(clk), .we(plen_we), .waddr(plen_waddr), .wdata(plen_wdata),
    .re(plen_re), .raddr(plen_raddr), .rdata(plen_rdata));

  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            KIND_PATTERN:  state_next = S_PAT_CHK;
            KIND_FINALIZE: state_next = open ? S_FIN_START : S_REPLY;
            KIND_TEXT:     state_next = open ? S_REPLY : S_TX_STEP;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_PAT_CHK: begin
        if (open && err == ST_OK && count < LEN_W'(MAX_PATTERN_LEN) && sym_ok) begin
          state_next = S_PAT_ALLOC;
        end else begin
          state_next = S_PAT_END;
        end
      end
      S_PAT_ALLOC: state_next = S_PAT_END;
      S_PAT_END: begin
        if (!cmd_q.pattern_end) state_next = S_IDLE;
        else if (!open || err != ST_OK) state_next = S_REPLY;
        else state_next = S_PAT_FINAL;
      end
      S_PAT_FINAL: state_next = S_REPLY;
      S_FIN_START: state_next = S_BFS_DEQ;
      S_BFS_DEQ:   state_next = bfs_more ? S_BFS_U : S_REPLY;
      S_BFS_U:     state_next = S_BFS_FU;
      S_BFS_FU:    state_next = S_BFS_CH;
      S_BFS_CH: begin
        state_next = (c == SYM_CNT_W'(ALPHABET_SIZE)) ? S_BFS_DEQ : S_BFS_V;
      end
      S_BFS_V: begin
        if (child_rdata == '0) state_next = S_BFS_CH;
        else if (u == '0) state_next = S_BFS_FL;
        else state_next = S_BFS_WALK;
      end
      S_BFS_WALK: state_next = S_BFS_WCHK;
      S_BFS_WCHK: begin
        if (child_rdata != '0 || f == '0) state_next = S_BFS_FL;
        else state_next = S_BFS_WLNK;
      end
      S_BFS_WLNK: state_next = S_BFS_WALK;
      S_BFS_FL:   state_next = S_BFS_FW;
      S_BFS_FW:   state_next = S_BFS_CH;
      S_TX_STEP:  state_next = S_TX_CHK;
      S_TX_CHK: begin
        if (tx_child != '0 || node == '0) state_next = S_TX_ADV;
        else state_next = S_TX_LNK;
      end
      S_TX_LNK:   state_next = S_TX_STEP;
      S_TX_ADV:   state_next = S_TX_N;
      S_TX_N:     state_next = (tx_first == '0) ? S_IDLE : S_TX_ID;
      S_TX_ID:    state_next = S_TX_REP;
      S_TX_REP: begin
        if (out_free) state_next = rep_last ? S_IDLE : S_TX_ID;
      end
      S_REPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Datapath, memory controls and results
  always_comb begin
    cmd_q_next      = cmd_q;
    clr_addr_next   = clr_addr;
    cursor_next     = cursor;
    count_next      = count;
    err_next        = err;
    nodes_used_next = nodes_used;
    pats_used_next  = pats_used;
    open_next       = open;
    scan_node_next  = scan_node;
    scan_pos_next   = scan_pos;
    node_next       = node;
    u_next          = u;
    fu_next         = fu;
    v_next          = v;
    f_next          = f;
    nn_next         = nn;
    head_next       = head;
    tail_next       = tail;
    c_next          = c;
    mid_next        = mid;
    k_next          = k;
    rsp_kind_next   = rsp_kind;
    rsp_status_next = rsp_status;
    rsp_pnum_next   = rsp_pnum;
    res_next        = '{kind: rsp_kind, status: rsp_status, pnum: rsp_pnum,
                        pos: '0, last: 1'b1};
    res_load        = 1'b0;
    cmd_pop         = 1'b0;
    clearing        = 1'b0;
    child_we = 1'b0; child_waddr = child_addr(cursor, cmd_q.symbol);
    child_wdata = nodes_used[NODE_W-1:0];
    child_re = 1'b0; child_raddr = child_addr(cursor, cmd_q.symbol);
    link_we = 1'b0; link_waddr = v; link_wdata = '{dict: '0, fail: '0};
    link_re = 1'b0; link_raddr = f;
    info_we = 1'b0; info_waddr = cursor;
    info_wdata = '{is_final: 1'b1, id: PAT_W'(pats_used)};
    info_re = 1'b0; info_raddr = cursor;
    plen_we = 1'b0; plen_waddr = PAT_W'(pats_used); plen_wdata = count;
    plen_re = 1'b0; plen_raddr = info_rdata.id;
    q_we = 1'b0; q_waddr = tail[NODE_W-1:0]; q_wdata = v;
    q_re = 1'b0; q_raddr = head[NODE_W-1:0];

    unique case (state)
      // Zero child slots and node flags
      S_CLEAR: begin
        clearing      = 1'b1;
        child_we      = 1'b1;
        child_waddr   = clr_addr;
        child_wdata   = '0;
        info_we       = (clr_addr < CHILD_AW'(NODE_COUNT));
        info_waddr    = clr_addr[NODE_W-1:0];
        info_wdata    = '{is_final: 1'b0, id: '0};
        clr_addr_next = clr_addr + CHILD_AW'(1);
      end
      // Take the next command
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cmd_q_next = cmd;
          unique case (cmd.kind)
            KIND_FINALIZE: begin
              rsp_kind_next   = REPLY_FINALIZE;
              rsp_status_next = ST_OK;
              rsp_pnum_next   = '0;
            end
            KIND_TEXT: begin
              rsp_kind_next   = REPLY_MATCH;
              rsp_status_next = ST_STILL_OPEN;
              rsp_pnum_next   = '0;
              node_next       = cmd.text_start ? '0 : scan_node;
              if (!open && cmd.text_start) scan_pos_next = '0;
            end
            default: ;
          endcase
        end
      end
      // Check the pattern byte and look up its child
      S_PAT_CHK: begin
        if (open && err == ST_OK) begin
          if (count >= LEN_W'(MAX_PATTERN_LEN)) err_next = ST_TOO_LONG;
          else if (!sym_ok) err_next = ST_SYMBOL_RANGE;
          else child_re = 1'b1;
        end
      end
      // Follow or allocate the child
      S_PAT_ALLOC: begin
        if (child_rdata != '0) begin
          cursor_next = child_rdata;
          count_next  = count + LEN_W'(1);
        end else if (nodes_used >= CNT_W'(NODE_COUNT)) begin
          err_next = ST_NODES_FULL;
        end else begin
          child_we        = 1'b1;
          cursor_next     = nodes_used[NODE_W-1:0];
          nodes_used_next = nodes_used + CNT_W'(1);
          count_next      = count + LEN_W'(1);
        end
      end
      // Close the pattern
      S_PAT_END: begin
        rsp_kind_next = REPLY_ADD;
        rsp_pnum_next = '0;
        if (cmd_q.pattern_end) begin
          if (!open || err != ST_OK) begin
            rsp_status_next = open ? err : ST_CLOSED;
            cursor_next = '0;
            count_next  = '0;
            err_next    = ST_OK;
          end else begin
            info_re = 1'b1;
          end
        end
      end
      S_PAT_FINAL: begin
        if (info_rdata.is_final) begin
          rsp_status_next = ST_DUPLICATE;
          rsp_pnum_next   = PNUM_W'(info_rdata.id);
        end else if (pats_used >= PCNT_W'(PATTERN_SLOTS)) begin
          rsp_status_next = ST_PATTERNS_FULL;
        end else begin
          rsp_status_next = ST_OK;
          rsp_pnum_next   = PNUM_W'(PAT_W'(pats_used));
          info_we         = 1'b1;
          plen_we         = 1'b1;
          pats_used_next  = pats_used + PCNT_W'(1);
        end
        cursor_next = '0;
        count_next  = '0;
        err_next    = ST_OK;
      end
      // Seed the breadth-first walk with the root
      S_FIN_START: begin
        cursor_next = '0;
        count_next  = '0;
        err_next    = ST_OK;
        q_we        = 1'b1;
        q_waddr     = '0;
        q_wdata     = '0;
        link_we     = 1'b1;
        link_waddr  = '0;
        head_next   = '0;
        tail_next   = CNT_W'(1);
      end
      S_BFS_DEQ: begin
        if (bfs_more) begin
          q_re      = 1'b1;
          head_next = head + CNT_W'(1);
        end else begin
          open_next = 1'b0;
        end
      end
      S_BFS_U: begin
        u_next     = q_rdata;
        link_re    = 1'b1;
        link_raddr = q_rdata;
        c_next     = '0;
      end
      S_BFS_FU: fu_next = link_rdata.fail;
      S_BFS_CH: begin
        if (c != SYM_CNT_W'(ALPHABET_SIZE)) begin
          child_re    = 1'b1;
          child_raddr = child_addr(u, SYM_W'(c));
        end
      end
      S_BFS_V: begin
        if (child_rdata == '0) begin
          c_next = c + SYM_CNT_W'(1);
        end else begin
          v_next = child_rdata;
          f_next = (u == '0) ? '0 : fu;
        end
      end
      // Walk failure links until the symbol has a child or the root is reached
      S_BFS_WALK: begin
        child_re    = 1'b1;
        child_raddr = child_addr(f, SYM_W'(c));
      end
      S_BFS_WCHK: begin
        if (child_rdata != '0) f_next = child_rdata;
        else if (f != '0) link_re = 1'b1;
      end
      S_BFS_WLNK: f_next = link_rdata.fail;
      S_BFS_FL: begin
        info_re    = 1'b1;
        info_raddr = f;
        link_re    = 1'b1;
      end
      // Store both links of the child and queue it
      S_BFS_FW: begin
        link_we    = 1'b1;
        link_wdata = '{dict: info_rdata.is_final ? f : link_rdata.dict, fail: f};
        if (tail < CNT_W'(NODE_COUNT)) begin
          q_we      = 1'b1;
          tail_next = tail + CNT_W'(1);
        end
        c_next = c + SYM_CNT_W'(1);
      end
      // Step the scan on a text byte
      S_TX_STEP: begin
        child_re    = sym_ok;
        child_raddr = child_addr(node, cmd_q.symbol);
      end
      S_TX_CHK: begin
        if (tx_child != '0) begin
          node_next = tx_child;
        end else if (node != '0) begin
          link_re    = 1'b1;
          link_raddr = node;
        end
      end
      S_TX_LNK: node_next = link_rdata.fail;
      S_TX_ADV: begin
        scan_node_next = node;
        scan_pos_next  = scan_pos + POS_W'(1);
        info_re        = 1'b1;
        info_raddr     = node;
        link_re        = 1'b1;
        link_raddr     = node;
      end
      S_TX_N: begin
        k_next = '0;
        if (tx_first != '0) begin
          info_re    = 1'b1;
          info_raddr = tx_first;
          link_re    = 1'b1;
          link_raddr = tx_first;
        end
      end
      S_TX_ID: begin
        mid_next   = info_rdata.id;
        nn_next    = link_rdata.dict;
        plen_re    = 1'b1;
        plen_raddr = info_rdata.id;
      end
      // Report one match, then chase the dictionary link
      S_TX_REP: begin
        res_next = '{kind: REPLY_MATCH, status: ST_OK, pnum: PNUM_W'(mid),
                     pos: scan_pos - POS_W'(plen_rdata), last: rep_last};
        if (out_free) begin
          res_load = 1'b1;
          k_next   = k + K_W'(1);
          if (!rep_last) begin
            info_re    = 1'b1;
            info_raddr = nn;
            link_re    = 1'b1;
            link_raddr = nn;
          end
        end
      end
      S_REPLY: begin
        res_load = out_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      cursor     <= '0;
      count      <= '0;
      err        <= ST_OK;
      nodes_used <= CNT_W'(1);
      pats_used  <= '0;
      open       <= 1'b1;
      scan_node  <= '0;
      scan_pos   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      cursor     <= cursor_next;
      count      <= count_next;
      err        <= err_next;
      nodes_used <= nodes_used_next;
      pats_used  <= pats_used_next;
      open       <= open_next;
      scan_node  <= scan_node_next;
      scan_pos   <= scan_pos_next;
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    node       <= node_next;
    u          <= u_next;
    fu         <= fu_next;
    v          <= v_next;
    f          <= f_next;
    nn         <= nn_next;
    head       <= head_next;
    tail       <= tail_next;
    c          <= c_next;
    mid        <= mid_next;
    k          <= k_next;
    rsp_kind   <= rsp_kind_next;
    rsp_status <= rsp_status_next;
    rsp_pnum   <= rsp_pnum_next;
    if (res_load) out_res <= res_next;
  end

  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= CNT_W'(NODE_COUNT))
    else $error("node count beyond table size");

  a_closed_stays: assert property (@(posedge clk) disable iff (rst)
    !open |=> !open)
    else $error("table reopened after finalize");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_BFS_CH) |-> (head <= tail && tail <= CNT_W'(NODE_COUNT)))
    else $error("breadth-first queue pointers out of order");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LEN_W'(MAX_PATTERN_LEN))
    else $error("pattern length beyond limit");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !res_load)
    else $error("result register overwritten while held");

endmodule

`default_nettype wire

/* design/multi_pattern_byte_matcher.sv */
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher
// Aho-Corasick engine over bytes: pattern loading, link build, text scan.
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata = symbol, tuser = {text_start, kind},
// tlast = pattern_end. Kind 0 adds a pattern byte, kind 1 finalizes the
// table, kind 2 scans a text byte; kind 3 is dropped. Output stream m_axis
// carries results: tuser = reply_kind, tdata = {pad, position, pattern
// number, status}, tlast marks the final result of an input item.
// A front stage queues up to two commands; the engine runs one at a time
// over single-port-read table RAMs with registered reads.
// A text byte reports at most 16 matches.
// After reset the engine zeroes the child table, one entry a cycle, over
// all NODE_COUNT * ALPHABET_SIZE entries (1048576); s_axis_tready stays low.
// A stalled receiver holds the result register; the engine waits on it
// while the front keeps taking items until its queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_byte_matcher (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // symbol [7:0]
  input  logic [mpbm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // kind [1:0], text_start [2]
  input  logic [mpbm_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status [2:0], pattern_number [10:3], match_position [42:11], zero [47:43]
  output logic [mpbm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // reply_kind [1:0]
  output logic [mpbm_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import mpbm_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    clearing;
  result_t res;

  mpbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser[1:0]),
    .in_symbol (s_axis_tdata[SYM_W-1:0]),
    .in_end    (s_axis_tlast),
    .in_start  (s_axis_tuser[2]),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mpbm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (res)
  );

  // Pack the result onto the output stream
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.pos, res.pnum, res.status};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
